// ----- rtl/core/byte_budget_lru_object_directory_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Object directory assertion macros
// Concurrent assertion helpers used by the object directory unit.
// ----------------------------------------------------------------------------
`ifndef BYTE_BUDGET_LRU_OBJECT_DIRECTORY_UNIT_DEFINES_SVH
`define BYTE_BUDGET_LRU_OBJECT_DIRECTORY_UNIT_DEFINES_SVH

// Plain implication checked on every edge outside reset.
`define BBL_ASSERT_IMP(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BBL_ASSERT_NXT(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/bbl_pkg.sv -----
// ----------------------------------------------------------------------------
// bbl_pkg
// Types and codes shared by the object directory modules.
// ----------------------------------------------------------------------------
`default_nettype none
package bbl_pkg;

    localparam int KEY_W   = 64;
    localparam int SIZE_W  = 32;
    localparam int TOTAL_W = 40;
    localparam int STAMP_W = 48;
    localparam int CNT_W   = 32;

    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_STORE = 2'd1,
        KIND_INVAL = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_HIT      = 3'd0,
        ST_MISS     = 3'd1,
        ST_INVALID  = 3'd2,
        ST_STORED   = 3'd3,
        ST_REJECTED = 3'd4,
        ST_INV_DONE = 3'd5,
        ST_EVICTED  = 3'd6
    } status_t;

    typedef enum logic {
        CFG_BUDGET = 1'b0,
        CFG_MAXOBJ = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [KEY_W-1:0]  key;
        logic [SIZE_W-1:0] object_bytes;
        logic              backing_ok;
    } in_item_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [KEY_W-1:0]  evicted_key;
        logic [SIZE_W-1:0] evicted_bytes;
        logic              last;
        logic [CNT_W-1:0]  hit_count;
        logic [CNT_W-1:0]  eviction_count;
        logic [CNT_W-1:0]  regeneration_count;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIND,
        S_DECIDE,
        S_LRU,
        S_EVICT,
        S_FREE,
        S_WRITE,
        S_EMIT_EV,
        S_EMIT
    } state_t;

endpackage
`default_nettype wire

// ----- rtl/core/byte_budget_lru_object_directory_unit.sv -----
// ----------------------------------------------------------------------------
// byte_budget_lru_object_directory_unit
// Object directory with LRU eviction under a byte budget.
// ----------------------------------------------------------------------------
// Channels: in_valid/in_ready carry one request (load, store, invalidate);
// out_valid/out_ready carry results, zero or more evictions followed by one
// final status with last set. cfg_valid/cfg_ready write the budget (index 0)
// or the largest object size (index 1); write only while idle.
// Throughput: one request at a time, in_ready is low from the accept edge on.
// A load, an invalidate or a rejected store takes one pass over all SLOTS
// slots to find its key. An accepted store adds a second pass for the LRU
// candidate, and each eviction one more pass.
// Each result is held in an output register until taken; a stalled receiver
// stalls the sequencer, nothing is lost. The final result may still wait
// while the next request is accepted.
// Reset clears all slot valid bits, the resident total, the access clock and
// the counters, and loads the default budget and maximum size.
`default_nettype none
module byte_budget_lru_object_directory_unit
    import bbl_pkg::*;
#(
    parameter int SLOTS = 16
)(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire in_item_t  in_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_item_t      out_data,
    input  wire logic      cfg_valid,
    output logic           cfg_ready,
    input  wire logic      cfg_index,
    input  wire logic [TOTAL_W-1:0] cfg_data
);
`include "byte_budget_lru_object_directory_unit_defines.svh"

    localparam int IDX_W = $clog2(SLOTS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    state_t state_reg, state_next;

    logic [SLOTS-1:0]   valid_reg;
    logic [KEY_W-1:0]   key_mem   [SLOTS];
    logic [SIZE_W-1:0]  size_mem  [SLOTS];
    logic [STAMP_W-1:0] stamp_mem [SLOTS];

    logic [TOTAL_W-1:0] budget_reg, resident_reg, total_reg;
    logic [SIZE_W-1:0]  maxobj_reg;
    logic [STAMP_W-1:0] clock_reg;
    logic [CNT_W-1:0]   hits_reg, evs_reg, regs_reg;
    in_item_t           req_reg;
    logic [IDX_W-1:0]   scan_reg;
    logic               out_valid_reg;
    out_item_t          out_reg;
    status_t            status_reg;
    logic [IDX_W-1:0]   tgt_reg;
    logic               have_slot_reg;

    logic scan_start, scan_step;
    logic match_found, free_found, lru_found;
    logic [IDX_W-1:0] match_idx, free_idx, lru_idx;

    logic [KEY_W-1:0]   rd_key;
    logic [STAMP_W-1:0] rd_stamp;
    logic [STAMP_W-1:0] clock_inc;
    logic               store_bad;
    logic               need_more;
    logic               out_load;

    assign rd_key   = key_mem[scan_reg];
    assign rd_stamp = stamp_mem[scan_reg];
    assign clock_inc = (&clock_reg) ? clock_reg : clock_reg + STAMP_W'(1);

    bbl_scan #(.IDX_W(IDX_W)) u_scan (
        .clk        (clk),
        .start      (scan_start),
        .step       (scan_step),
        .idx        (scan_reg),
        .valid      (valid_reg[scan_reg]),
        .slot_key   (rd_key),
        .slot_stamp (rd_stamp),
        .key        (req_reg.key),
        .skip_en    (have_slot_reg),
        .skip_idx   (tgt_reg),
        .match_found(match_found),
        .match_idx  (match_idx),
        .free_found (free_found),
        .free_idx   (free_idx),
        .lru_found  (lru_found),
        .lru_idx    (lru_idx)
    );

    assign store_bad = req_reg.object_bytes == '0 ||
                       req_reg.object_bytes > maxobj_reg ||
                       TOTAL_W'(req_reg.object_bytes) > budget_reg ||
                       !req_reg.backing_ok;
    // More room needed: no slot for a new key, or over budget.
    assign need_more = (!have_slot_reg && !free_found) || total_reg > budget_reg;

    assign in_ready  = state_reg == S_IDLE;
    assign cfg_ready = state_reg == S_IDLE;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (in_valid && in_data.kind != KIND_NONE)
                    state_next = S_FIND;
            S_FIND:
                if (scan_reg == LAST_IDX)
                    state_next = S_DECIDE;
            S_DECIDE:
                if (req_reg.kind == KIND_STORE && !store_bad)
                    state_next = S_LRU;
                else
                    state_next = S_EMIT;
            S_LRU:
                if (scan_reg == LAST_IDX)
                    state_next = S_EVICT;
            S_EVICT:
                state_next = (need_more && lru_found) ? S_EMIT_EV : S_WRITE;
            S_EMIT_EV:
                if (!out_valid_reg || out_ready)
                    state_next = S_LRU;
            S_FREE:
                state_next = S_WRITE;
            S_WRITE:
                state_next = S_EMIT;
            S_EMIT:
                if (!out_valid_reg || out_ready)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        scan_start = (state_reg == S_IDLE) || (state_reg == S_DECIDE) ||
                     (state_reg == S_EMIT_EV);
        scan_step  = (state_reg == S_FIND) || (state_reg == S_LRU);
        out_load   = (state_reg == S_EMIT || state_reg == S_EMIT_EV) &&
                     (!out_valid_reg || out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            budget_reg    <= TOTAL_W'(268435456);
            maxobj_reg    <= SIZE_W'(1048576);
            resident_reg  <= '0;
            clock_reg     <= '0;
            hits_reg      <= '0;
            evs_reg       <= '0;
            regs_reg      <= '0;
            out_valid_reg <= 1'b0;
            scan_reg      <= '0;
            have_slot_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    scan_reg <= '0;
                    if (cfg_valid)
                    begin
                        if (cfg_index == CFG_BUDGET)
                            budget_reg <= cfg_data;
                        else
                            maxobj_reg <= cfg_data[SIZE_W-1:0];
                    end
                end
                S_FIND, S_LRU:
                    scan_reg <= scan_reg + IDX_W'(1);
                S_DECIDE:
                begin
                    scan_reg      <= '0;
                    have_slot_reg <= match_found;
                    tgt_reg       <= match_idx;
                    total_reg     <= resident_reg + TOTAL_W'(req_reg.object_bytes) -
                                     (match_found ? TOTAL_W'(size_mem[match_idx]) : '0);
                    case (req_reg.kind)
                        KIND_LOAD:
                            if (!match_found)
                                status_reg <= ST_MISS;
                            else if (req_reg.backing_ok &&
                                     size_mem[match_idx] <= maxobj_reg)
                            begin
                                status_reg <= ST_HIT;
                                stamp_mem[match_idx] <= clock_inc;
                                clock_reg <= clock_inc;
                                hits_reg  <= hits_reg + CNT_W'(1);
                            end
                            else
                            begin
                                status_reg <= ST_INVALID;
                                valid_reg[match_idx] <= 1'b0;
                                resident_reg <= resident_reg -
                                                TOTAL_W'(size_mem[match_idx]);
                                regs_reg <= regs_reg + CNT_W'(1);
                            end
                        KIND_STORE:
                            if (store_bad)
                                status_reg <= ST_REJECTED;
                            else
                                status_reg <= ST_STORED;
                        default:
                        begin
                            status_reg <= ST_INV_DONE;
                            if (match_found)
                            begin
                                valid_reg[match_idx] <= 1'b0;
                                resident_reg <= resident_reg -
                                                TOTAL_W'(size_mem[match_idx]);
                                regs_reg <= regs_reg + CNT_W'(1);
                            end
                        end
                    endcase
                end
                S_EVICT:
                    if (need_more && lru_found)
                    begin
                        valid_reg[lru_idx] <= 1'b0;
                        resident_reg <= resident_reg - TOTAL_W'(size_mem[lru_idx]);
                        total_reg    <= total_reg - TOTAL_W'(size_mem[lru_idx]);
                        evs_reg      <= evs_reg + CNT_W'(1);
                    end
                S_EMIT_EV:
                    if (out_load)
                    begin
                        out_reg  <= {ST_EVICTED, key_mem[lru_idx], size_mem[lru_idx],
                                     1'b0, hits_reg, evs_reg, regs_reg};
                        scan_reg <= '0;
                    end
                S_WRITE:
                begin
                    // No slot left: the store reports done without an insert.
                    if (have_slot_reg || free_found)
                    begin
                        valid_reg[have_slot_reg ? tgt_reg : free_idx] <= 1'b1;
                        key_mem[have_slot_reg ? tgt_reg : free_idx]   <= req_reg.key;
                        size_mem[have_slot_reg ? tgt_reg : free_idx]  <=
                            req_reg.object_bytes;
                        stamp_mem[have_slot_reg ? tgt_reg : free_idx] <= clock_inc;
                        clock_reg    <= clock_inc;
                        resident_reg <= resident_reg + TOTAL_W'(req_reg.object_bytes) -
                                        (have_slot_reg ? TOTAL_W'(size_mem[tgt_reg]) : '0);
                    end
                    status_reg <= ST_STORED;
                end
                S_EMIT:
                    if (out_load)
                        out_reg <= {status_reg, KEY_W'(0), SIZE_W'(0), 1'b1,
                                    hits_reg, evs_reg, regs_reg};
                default:
                    ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
            req_reg <= in_data;
    end

    `BBL_ASSERT_IMP(a_busy_no_in, clk, rst_n, state_reg != S_IDLE, !in_ready, "ready while busy")
    `BBL_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result dropped")
    `BBL_ASSERT_IMP(a_ev_notlast, clk, rst_n, out_valid && out_data.status == ST_EVICTED, !out_data.last, "eviction marked last")

endmodule
`default_nettype wire

// ----- rtl/core/bbl_scan.sv -----
// ----------------------------------------------------------------------------
// bbl_scan
// Shared slot compare unit: one slot per cycle while step is high, tracks key match, free slot
// and least-recently-used candidate.
// ----------------------------------------------------------------------------
`default_nettype none
module bbl_scan
    import bbl_pkg::*;
#(
    parameter int IDX_W = 4
)(
    input  wire logic               clk,
    input  wire logic               start,
    input  wire logic               step,
    input  wire logic [IDX_W-1:0]   idx,
    input  wire logic               valid,
    input  wire logic [KEY_W-1:0]   slot_key,
    input  wire logic [STAMP_W-1:0] slot_stamp,
    input  wire logic [KEY_W-1:0]   key,
    input  wire logic               skip_en,
    input  wire logic [IDX_W-1:0]   skip_idx,
    output logic                    match_found,
    output logic [IDX_W-1:0]        match_idx,
    output logic                    free_found,
    output logic [IDX_W-1:0]        free_idx,
    output logic                    lru_found,
    output logic [IDX_W-1:0]        lru_idx
);

    logic [STAMP_W-1:0] lru_stamp_reg;
    logic [KEY_W-1:0]   lru_key_reg;
    logic               better;

    // Older stamp wins, equal stamps fall back to the smaller key.
    always_comb
    begin
        better = valid && !(skip_en && idx == skip_idx) &&
                 (!lru_found || slot_stamp < lru_stamp_reg ||
                  (slot_stamp == lru_stamp_reg && slot_key < lru_key_reg));
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            match_found <= 1'b0;
            free_found  <= 1'b0;
            lru_found   <= 1'b0;
        end
        else if (step)
        begin
            if (valid && slot_key == key && !match_found)
            begin
                match_found <= 1'b1;
                match_idx   <= idx;
            end
            if (!valid && !free_found)
            begin
                free_found <= 1'b1;
                free_idx   <= idx;
            end
            if (better)
            begin
                lru_found     <= 1'b1;
                lru_idx       <= idx;
                lru_stamp_reg <= slot_stamp;
                lru_key_reg   <= slot_key;
            end
        end
    end

endmodule
`default_nettype wire
